// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker in dfpa_checker.sv
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// next-cycle implication that also holds through reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("check through reset failed");

`endif

// File: rtl/dfpa_pkg.sv
// shared types, codes and digit helpers for the decimal fixed-point unit
// no dependencies
package dfpa_pkg;

  localparam int INT_DIGITS_DEF      = 60;
  localparam int LAST_POSITION_DEF   = 120;
  localparam int DIGITS_PER_WORD_DEF = 16;

  localparam int WORD_W   = 64;
  localparam int ACTION_W = 2;
  localparam int DIGIT_W  = 4;
  localparam int RADIX    = 10;

  typedef logic [DIGIT_W-1:0] digit_t;

  localparam digit_t DIGIT_MAX = 4'd9;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_RSV = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_ROTATE,
    CELL_MUL,
    CELL_OUT,
    CELL_CLEAR
  } cell_op_t;

  typedef enum logic [1:0] {
    SER_ADDSUB,
    SER_NEG,
    SER_CARRY
  } ser_mode_t;

  typedef struct packed {
    ser_mode_t mode;
    logic      first;
    logic      sub;
    logic      neg_a;
    logic      neg_b;
    logic      zero_in;
  } ser_ctrl_t;

  function automatic digit_t sat_digit(input digit_t n);
    return (n > DIGIT_MAX) ? DIGIT_MAX : n;
  endfunction

  // returns {carry, digit}
  function automatic logic [DIGIT_W:0] digit_add(input digit_t a, input digit_t b,
                                                 input logic c);
    logic [DIGIT_W:0] s;
    s = {1'b0, a} + {1'b0, b} + {{DIGIT_W{1'b0}}, c};
    if (s > {1'b0, DIGIT_MAX}) begin
      return {1'b1, DIGIT_W'(s - (DIGIT_W+1)'(RADIX))};
    end
    return {1'b0, s[DIGIT_W-1:0]};
  endfunction

endpackage

// File: rtl/dfpa_if.sv
// operand and result channels of the decimal fixed-point unit
// depends on dfpa_pkg
interface dfpa_in_if;
  logic                                valid;
  logic                                ready;
  logic [dfpa_pkg::ACTION_W-1:0]       action;
  logic [dfpa_pkg::WORD_W-1:0]         word_a;
  logic [dfpa_pkg::WORD_W-1:0]         word_b;
  logic                                final_word;

  modport source(output valid, action, word_a, word_b, final_word, input ready);
  modport sink(input valid, action, word_a, word_b, final_word, output ready);
endinterface

interface dfpa_out_if;
  logic                                valid;
  logic                                ready;
  logic [dfpa_pkg::WORD_W-1:0]         result_word;
  logic                                last_result;
  logic                                bad_input;

  modport source(output valid, result_word, last_result, bad_input, input ready);
  modport sink(input valid, result_word, last_result, bad_input, output ready);
endinterface

// File: rtl/decimal_fixed_point_alu.sv
// top level of the decimal fixed-point add / subtract / multiply unit
// depends on dfpa_pkg, dfpa_if, dfpa_cell, dfpa_serial, dfpa_bline
//
//   channel  | dir | handshake    | payload
//   in_ch    | in  | valid/ready  | action, word_a, word_b, final_word
//   out_ch   | out | valid/ready  | result_word, last_result, bad_input
//
// operand words are taken one a cycle while idle; a final item starts the operation
// add/subtract: one pass of every digit through the digit-serial adder, then the result words
// multiply: a serial complement pass, a load of the b delay line, one partial-product step
//   per digit of a, a carry pass and a second complement pass, then the result words
// results: one word per accepted output, held while out_ch.ready is low
// reset: synchronous, clears every digit cell, so no clearing pass is needed
module decimal_fixed_point_alu #(
  parameter int INT_DIGITS      = dfpa_pkg::INT_DIGITS_DEF,
  parameter int LAST_POSITION   = dfpa_pkg::LAST_POSITION_DEF,
  parameter int DIGITS_PER_WORD = dfpa_pkg::DIGITS_PER_WORD_DEF
) (
  input logic       clk,
  input logic       rst_n,
  dfpa_in_if.sink   in_ch,
  dfpa_out_if.source out_ch
);
  import dfpa_pkg::*;

  localparam int NPOS      = LAST_POSITION + 1;
  localparam int NUM_WORDS = (NPOS + DIGITS_PER_WORD - 1) / DIGITS_PER_WORD;
  localparam int WC_W      = $clog2(NUM_WORDS + 1);
  localparam int CNT_W     = $clog2(NPOS + 1);
  localparam int ACC_W     = $clog2(162 * LAST_POSITION + 1);
  localparam int BLEN      = LAST_POSITION + INT_DIGITS;

  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_NEG, S_LDB, S_MUL, S_CARRY, S_NEG2, S_OUT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WC_W-1:0]   wc_r;
  logic [WC_W-1:0]   oc_r;
  logic              err_r, sub_r, neg_a_r, neg_b_r, neg_r_r;

  logic              in_acc, out_acc, last_word, bad_nib;
  cell_op_t          cell_op;
  ser_ctrl_t         ser_ctrl;
  digit_t            ser_a, ser_b;

  digit_t            a_q [NPOS];
  digit_t            b_q [NPOS];
  logic [ACC_W-1:0]  acc_q [NPOS];
  digit_t            bl [BLEN];
  logic [WORD_W-1:0] res_word;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_acc   = out_ch.valid && out_ch.ready;
  assign last_word = (oc_r == WC_W'(NUM_WORDS - 1));

  // nibbles above nine, only where the place exists
  always_comb begin
    bad_nib = 1'b0;
    for (int d = 0; d < DIGITS_PER_WORD; d++) begin
      if (int'(wc_r) * DIGITS_PER_WORD + d <= LAST_POSITION) begin
        if (in_ch.word_a[DIGIT_W*(DIGITS_PER_WORD-1-d) +: DIGIT_W] > DIGIT_MAX ||
            in_ch.word_b[DIGIT_W*(DIGITS_PER_WORD-1-d) +: DIGIT_W] > DIGIT_MAX) begin
          bad_nib = 1'b1;
        end
      end
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:  cell_op = (in_acc && wc_r < WC_W'(NUM_WORDS)) ? CELL_LOAD : CELL_HOLD;
      S_ADD, S_NEG, S_CARRY, S_NEG2: cell_op = CELL_ROTATE;
      S_LDB:   cell_op = CELL_HOLD;
      S_MUL:   cell_op = CELL_MUL;
      S_OUT:   cell_op = out_acc ? (last_word ? CELL_CLEAR : CELL_OUT) : CELL_HOLD;
      default: cell_op = CELL_HOLD;
    endcase
  end

  always_comb begin
    ser_ctrl.first   = (cnt_r == '0);
    ser_ctrl.sub     = 1'b0;
    ser_ctrl.neg_a   = 1'b0;
    ser_ctrl.neg_b   = 1'b0;
    ser_ctrl.zero_in = (cnt_r == CNT_W'(LAST_POSITION));
    ser_ctrl.mode    = SER_NEG;
    unique case (state_r)
      S_ADD: begin
        ser_ctrl.mode = SER_ADDSUB;
        ser_ctrl.sub  = sub_r;
      end
      S_NEG: begin
        // sign digits are still in place on the first step
        ser_ctrl.neg_a = ser_ctrl.first ? (a_q[0] != '0) : neg_a_r;
        ser_ctrl.neg_b = ser_ctrl.first ? (b_q[0] != '0) : neg_b_r;
      end
      S_CARRY: ser_ctrl.mode = SER_CARRY;
      S_NEG2:  ser_ctrl.neg_a = neg_r_r;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      wc_r    <= '0;
      oc_r    <= '0;
      err_r   <= 1'b0;
      sub_r   <= 1'b0;
      neg_a_r <= 1'b0;
      neg_b_r <= 1'b0;
      neg_r_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (wc_r < WC_W'(NUM_WORDS)) begin
              wc_r <= wc_r + 1'b1;
              if (bad_nib) err_r <= 1'b1;
            end else begin
              err_r <= 1'b1;
            end
            if (in_ch.final_word) begin
              sub_r   <= (action_t'(in_ch.action) == ACT_SUB);
              cnt_r   <= '0;
              state_r <= (action_t'(in_ch.action) == ACT_MUL) ? S_NEG : S_ADD;
            end
          end
        end
        S_ADD: begin
          if (cnt_r == CNT_W'(NPOS - 1)) begin
            oc_r    <= '0;
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_NEG: begin
          if (cnt_r == '0) begin
            neg_a_r <= (a_q[0] != '0);
            neg_b_r <= (b_q[0] != '0);
          end
          if (cnt_r == CNT_W'(NPOS - 1)) begin
            neg_r_r <= neg_a_r ^ neg_b_r;
            state_r <= S_LDB;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_LDB: begin
          cnt_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (cnt_r == CNT_W'(LAST_POSITION - 1)) begin
            cnt_r   <= '0;
            state_r <= S_CARRY;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_CARRY: begin
          if (cnt_r == CNT_W'(NPOS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_NEG2;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_NEG2: begin
          if (cnt_r == CNT_W'(NPOS - 1)) begin
            oc_r    <= '0;
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (last_word) begin
              wc_r    <= '0;
              err_r   <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              oc_r <= oc_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  dfpa_serial #(.ACC_W(ACC_W)) u_serial (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ser_ctrl),
    .a_top   (a_q[LAST_POSITION]),
    .b_top   (b_q[LAST_POSITION]),
    .acc_top (acc_q[LAST_POSITION]),
    .a_in    (ser_a),
    .b_in    (ser_b)
  );

  dfpa_bline #(.LEN(BLEN), .NPOS(NPOS)) u_bline (
    .clk   (clk),
    .load  (state_r == S_LDB),
    .shift (state_r == S_MUL),
    .b_dig (b_q),
    .line  (bl)
  );

  for (genvar x = 0; x < NPOS; x++) begin : g_cell
    localparam int WIDX = x / DIGITS_PER_WORD;
    digit_t           a_up, b_up, a_down, a_far, tap;
    logic [ACC_W-1:0] acc_up;

    if (x == 0) begin : g_head
      assign a_up   = ser_a;
      assign b_up   = ser_b;
      assign acc_up = '0;
      assign tap    = '0;
    end else begin : g_body
      assign a_up   = a_q[x-1];
      assign b_up   = b_q[x-1];
      assign acc_up = acc_q[x-1];
      assign tap    = bl[x + INT_DIGITS - 1];
    end

    if (x < LAST_POSITION) begin : g_dn
      assign a_down = a_q[x+1];
    end else begin : g_dn_end
      assign a_down = '0;
    end

    if (x + DIGITS_PER_WORD <= LAST_POSITION) begin : g_far
      assign a_far = a_q[x+DIGITS_PER_WORD];
    end else begin : g_far_end
      assign a_far = '0;
    end

    dfpa_cell #(.POS(x), .DPW(DIGITS_PER_WORD), .ACC_W(ACC_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (cell_op),
      .load_en (wc_r == WC_W'(WIDX)),
      .word_a  (in_ch.word_a),
      .word_b  (in_ch.word_b),
      .a_up    (a_up),
      .b_up    (b_up),
      .acc_up  (acc_up),
      .a_down  (a_down),
      .a_far   (a_far),
      .mul_a   (a_q[1]),
      .mul_tap (tap),
      .a_q     (a_q[x]),
      .b_q     (b_q[x]),
      .acc_q   (acc_q[x])
    );
  end

  // the front of the row is always the word to send
  for (genvar d = 0; d < WORD_W / DIGIT_W; d++) begin : g_pack
    if (d < DIGITS_PER_WORD && d <= LAST_POSITION) begin : g_dig
      assign res_word[DIGIT_W*(DIGITS_PER_WORD-1-d) +: DIGIT_W] = a_q[d];
    end else if (d >= DIGITS_PER_WORD) begin : g_hi
      assign res_word[DIGIT_W*d +: DIGIT_W] = '0;
    end else begin : g_none
      assign res_word[DIGIT_W*(DIGITS_PER_WORD-1-d) +: DIGIT_W] = '0;
    end
  end

  assign out_ch.result_word = res_word;
  assign out_ch.last_result = last_word;
  assign out_ch.bad_input   = err_r;

endmodule

// File: rtl/dfpa_cell.sv
// one digit position: operand a and b digits plus the product accumulator
// depends on dfpa_pkg
module dfpa_cell #(
  parameter int POS   = 0,
  parameter int DPW   = dfpa_pkg::DIGITS_PER_WORD_DEF,
  parameter int ACC_W = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dfpa_pkg::cell_op_t         op,
  input  logic                       load_en,
  input  logic [dfpa_pkg::WORD_W-1:0] word_a,
  input  logic [dfpa_pkg::WORD_W-1:0] word_b,
  input  dfpa_pkg::digit_t           a_up,
  input  dfpa_pkg::digit_t           b_up,
  input  logic [ACC_W-1:0]           acc_up,
  input  dfpa_pkg::digit_t           a_down,
  input  dfpa_pkg::digit_t           a_far,
  input  dfpa_pkg::digit_t           mul_a,
  input  dfpa_pkg::digit_t           mul_tap,
  output dfpa_pkg::digit_t           a_q,
  output dfpa_pkg::digit_t           b_q,
  output logic [ACC_W-1:0]           acc_q
);
  import dfpa_pkg::*;

  localparam int SH = DIGIT_W * (DPW - 1 - (POS % DPW));

  digit_t              a_r;
  digit_t              b_r;
  logic [ACC_W-1:0]    acc_r;
  logic [2*DIGIT_W-1:0] prod;

  assign prod = mul_a * mul_tap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r   <= '0;
      b_r   <= '0;
      acc_r <= '0;
    end else begin
      unique case (op)
        CELL_HOLD: begin
        end
        CELL_LOAD: begin
          if (load_en) begin
            a_r <= sat_digit(word_a[SH +: DIGIT_W]);
            b_r <= sat_digit(word_b[SH +: DIGIT_W]);
          end
        end
        CELL_ROTATE: begin
          a_r   <= a_up;
          b_r   <= b_up;
          acc_r <= acc_up;
        end
        CELL_MUL: begin
          a_r   <= a_down;
          acc_r <= acc_r + ACC_W'(prod);
        end
        CELL_OUT: begin
          a_r <= a_far;
        end
        CELL_CLEAR: begin
          a_r   <= '0;
          b_r   <= '0;
          acc_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign a_q   = a_r;
  assign b_q   = b_r;
  assign acc_q = acc_r;

endmodule

// File: rtl/dfpa_serial.sv
// digit-serial unit at the bottom of the cell row: add, complement, carry resolve
// depends on dfpa_pkg
module dfpa_serial #(
  parameter int ACC_W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dfpa_pkg::ser_ctrl_t ctrl,
  input  dfpa_pkg::digit_t   a_top,
  input  dfpa_pkg::digit_t   b_top,
  input  logic [ACC_W-1:0]   acc_top,
  output dfpa_pkg::digit_t   a_in,
  output dfpa_pkg::digit_t   b_in
);
  import dfpa_pkg::*;

  // divide by ten through a scaled reciprocal
  localparam int SHIFT  = ACC_W + 4;
  localparam int RECIP  = (2**SHIFT + RADIX - 1) / RADIX;
  localparam int PROD_W = ACC_W + SHIFT;

  logic               ca_r, ca_nxt, cb_r, cb_nxt;
  logic [ACC_W-1:0]   cacc_r, cacc_nxt;
  logic               ca, cb;
  logic [ACC_W-1:0]   cacc;
  logic [DIGIT_W:0]   sum_ab, neg_a_s, neg_b_s;
  digit_t             b_eff;
  logic [ACC_W-1:0]   v, q, rem;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    unique case (ctrl.mode)
      SER_ADDSUB: ca = ctrl.first ? ctrl.sub : ca_r;
      SER_NEG:    ca = ctrl.first ? 1'b1 : ca_r;
      default:    ca = ca_r;
    endcase
    cb   = ctrl.first ? 1'b1 : cb_r;
    cacc = ctrl.first ? '0 : cacc_r;
  end

  assign b_eff   = ctrl.sub ? DIGIT_W'(DIGIT_MAX - b_top) : b_top;
  assign sum_ab  = digit_add(a_top, b_eff, ca);
  assign neg_a_s = digit_add(DIGIT_W'(DIGIT_MAX - a_top), '0, ca);
  assign neg_b_s = digit_add(DIGIT_W'(DIGIT_MAX - b_top), '0, cb);

  assign v    = acc_top + cacc;
  assign prod = PROD_W'(v) * PROD_W'(RECIP);
  assign q    = ACC_W'(prod >> SHIFT);
  assign rem  = v - ACC_W'(q * ACC_W'(RADIX));

  always_comb begin
    a_in     = a_top;
    b_in     = b_top;
    ca_nxt   = ca;
    cb_nxt   = cb;
    cacc_nxt = cacc;
    unique case (ctrl.mode)
      SER_ADDSUB: begin
        a_in   = sum_ab[DIGIT_W-1:0];
        ca_nxt = sum_ab[DIGIT_W];
      end
      SER_NEG: begin
        if (ctrl.neg_a) a_in = neg_a_s[DIGIT_W-1:0];
        if (ctrl.neg_b) b_in = neg_b_s[DIGIT_W-1:0];
        ca_nxt = neg_a_s[DIGIT_W];
        cb_nxt = neg_b_s[DIGIT_W];
      end
      SER_CARRY: begin
        a_in     = ctrl.zero_in ? '0 : rem[DIGIT_W-1:0];
        cacc_nxt = q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r   <= 1'b0;
      cb_r   <= 1'b0;
      cacc_r <= '0;
    end else begin
      ca_r   <= ca_nxt;
      cb_r   <= cb_nxt;
      cacc_r <= cacc_nxt;
    end
  end

endmodule

// File: rtl/dfpa_bline.sv
// operand b delay line for the multiply; each step moves it one place up
// depends on dfpa_pkg
module dfpa_bline #(
  parameter int LEN  = 180,
  parameter int NPOS = 121
) (
  input  logic             clk,
  input  logic             load,
  input  logic             shift,
  input  dfpa_pkg::digit_t b_dig [NPOS],
  output dfpa_pkg::digit_t line [LEN]
);
  import dfpa_pkg::*;

  digit_t line_r [LEN];

  // sign place and places past the last position load as zero
  always_ff @(posedge clk) begin
    for (int x = 0; x < LEN; x++) begin
      if (load) begin
        line_r[x] <= (x >= 1 && x < NPOS) ? b_dig[x < NPOS ? x : 0] : '0;
      end else if (shift) begin
        line_r[x] <= (x == 0) ? '0 : line_r[x == 0 ? 0 : x-1];
      end
    end
  end

  assign line = line_r;

endmodule

// File: rtl/dfpa_checker.sv
// port-level checks on the decimal fixed-point unit, bound to its top level
// depends on assert_macros.svh and decimal_fixed_point_alu
module dfpa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_last,
  input logic [dfpa_pkg::WORD_W-1:0]  out_word
);
  `include "assert_macros.svh"

  // a stalled result item keeps its word
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word) && $stable(out_last))

  // operands are never taken while results are pending
  `ASSERT_IMPL(a_one_side, clk, rst_n, in_ready, !out_valid)

  // after the last result item the unit is back to taking operands
  `ASSERT_NEXT(a_done, clk, rst_n, out_valid && out_ready && out_last, !out_valid && in_ready)

  // reset leaves the unit waiting for operands
  `ASSERT_NEXT_ALWAYS(a_reset, clk, !rst_n, !out_valid && in_ready)

endmodule

bind decimal_fixed_point_alu dfpa_checker u_dfpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_result),
  .out_word  (out_ch.result_word)
);

// File: tb/sv/dfpa_tb_if.sv
// channel interfaces used by the testbench are the rtl ones in dfpa_if.sv
// this file holds a small package of testbench-side constants; depends on dfpa_pkg
package dfpa_tb_pkg;
  import dfpa_pkg::*;
  localparam int NPOS      = LAST_POSITION_DEF + 1;
  localparam int NUM_WORDS = (NPOS + DIGITS_PER_WORD_DEF - 1) / DIGITS_PER_WORD_DEF;
endpackage

// File: tb/sv/decimal_fixed_point_alu_checker.sv
// checker for the decimal fixed-point unit: watches both channels, predicts result words
// depends on dfpa_pkg, dfpa_tb_pkg and the channel interfaces in dfpa_if
module decimal_fixed_point_alu_checker (
  input  logic   clk,
  input  logic   rst_n,
  dfpa_in_if     in_ch,
  dfpa_out_if    out_ch,
  output int     fail_count,
  output int     pending,
  output int     words_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import dfpa_pkg::*;
  import dfpa_tb_pkg::*;

  localparam int ND = DIGITS_PER_WORD_DEF;
  localparam int LP = LAST_POSITION_DEF;
  localparam int ID = INT_DIGITS_DEF;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
    logic              bad;
  } result_item_t;

  typedef int digits_t[NPOS];

  digits_t     dig_a, dig_b;
  int          words_taken;
  bit          flagged;
  result_item_t expected_words[$];

  assign pending = expected_words.size();

  function automatic digits_t negate(digits_t d);
    int c, n;
    c = 1;
    for (int i = LP; i >= 0; i--) begin
      n = 9 - d[i] + c;
      if (n > 9) begin n -= 10; c = 1; end else c = 0;
      d[i] = n;
    end
    return d;
  endfunction

  function automatic digits_t add_digits(digits_t a, digits_t b);
    digits_t r;
    int c, n;
    c = 0;
    for (int i = LP; i >= 0; i--) begin
      n = a[i] + b[i] + c;
      if (n > 9) begin n -= 10; c = 1; end else c = 0;
      r[i] = n;
    end
    return r;
  endfunction

  function automatic digits_t mul_digits(digits_t a, digits_t b);
    digits_t r;
    int sums[NPOS];
    bit na, nb;
    int k, v, c;
    na = a[0] != 0;
    nb = b[0] != 0;
    if (na) a = negate(a);
    if (nb) b = negate(b);
    for (int i = 0; i < NPOS; i++) sums[i] = 0;
    for (int i = 1; i <= LP; i++)
      for (int j = 1; j <= LP; j++) begin
        k = i + j - ID;
        if (k >= 1 && k <= LP) sums[k] += a[i] * b[j];
      end
    r[0] = 0;
    c = 0;
    for (int i = LP; i >= 1; i--) begin
      v = sums[i] + c;
      c = v / 10;
      r[i] = v % 10;
    end
    if (na != nb) r = negate(r);
    return r;
  endfunction

  task automatic clear_operands();
    for (int i = 0; i < NPOS; i++) begin dig_a[i] = 0; dig_b[i] = 0; end
    words_taken = 0;
    flagged = 0;
  endtask

  task automatic take_item(logic [ACTION_W-1:0] act, logic [WORD_W-1:0] wa,
                           logic [WORD_W-1:0] wb, logic fin);
    digits_t r;
    result_item_t e;
    int pos, sh, da, db;
    if (words_taken < NUM_WORDS) begin
      for (int d = 0; d < ND; d++) begin
        pos = words_taken * ND + d;
        sh = 4 * (ND - 1 - d);
        da = int'((wa >> sh) & 64'd15);
        db = int'((wb >> sh) & 64'd15);
        if (pos <= LP) begin
          if (da > 9) begin da = 9; flagged = 1; end
          if (db > 9) begin db = 9; flagged = 1; end
          dig_a[pos] = da;
          dig_b[pos] = db;
        end
      end
      words_taken++;
    end else flagged = 1;
    if (!fin) return;
    case (action_t'(act))
      ACT_SUB: r = add_digits(dig_a, negate(dig_b));
      ACT_MUL: r = mul_digits(dig_a, dig_b);
      default: r = add_digits(dig_a, dig_b);
    endcase
    for (int w = 0; w < NUM_WORDS; w++) begin
      e.word = '0;
      for (int d = 0; d < ND; d++) begin
        pos = w * ND + d;
        if (pos <= LP) e.word |= WORD_W'(r[pos]) << (4 * (ND - 1 - d));
      end
      e.last = (w == NUM_WORDS - 1);
      e.bad = flagged;
      expected_words.push_back(e);
    end
    clear_operands();
  endtask

  initial begin
    fail_count = 0;
    words_seen = 0;
    clear_operands();
  end

  always @(posedge clk) begin
    result_item_t e;
    if (rst_n && in_ch.valid && in_ch.ready)
      take_item(in_ch.action, in_ch.word_a, in_ch.word_b, in_ch.final_word);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result word %h", out_ch.result_word);
      end else begin
        e = expected_words.pop_front();
        if (out_ch.result_word !== e.word || out_ch.last_result !== e.last ||
            out_ch.bad_input !== e.bad) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected %h last %b bad %b, got %h last %b bad %b",
                     e.word, e.last, e.bad, out_ch.result_word, out_ch.last_result,
                     out_ch.bad_input);
        end
      end
    end
  end
endmodule

// File: tb/sv/decimal_fixed_point_alu_tb.sv
// stimulus and verdict for the decimal fixed-point unit
// depends on dfpa_pkg, dfpa_tb_pkg, dfpa_if, the checker and the rtl
module decimal_fixed_point_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dfpa_pkg::*;
  import dfpa_tb_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending, words_seen;
  int   send_idle = 0, recv_stall = 0;
  bit   hold_off = 0;
  int   idle_cycles = 0;
  int   items_sent = 0;

  dfpa_in_if  in_ch();
  dfpa_out_if out_ch();

  decimal_fixed_point_alu i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  decimal_fixed_point_alu_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending), .words_seen(words_seen)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.action = ACT_ADD;
    in_ch.word_a = '0;
    in_ch.word_b = '0;
    in_ch.final_word = 0;
    out_ch.ready = 0;
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("decimal_fixed_point_alu_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] rand_bcd(int bad_pct);
    logic [WORD_W-1:0] w;
    for (int d = 0; d < 16; d++)
      w[4*d +: 4] = ($urandom_range(99) < bad_pct) ? 4'($urandom_range(15))
                                                   : 4'($urandom_range(9));
    return w;
  endfunction

  // driven on the falling edge, so blocking updates cannot race the sampling edge
  task automatic send(action_t act, logic [WORD_W-1:0] wa, logic [WORD_W-1:0] wb,
                      logic fin);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
    in_ch.valid = 1;
    in_ch.action = act;
    in_ch.word_a = wa;
    in_ch.word_b = wb;
    in_ch.final_word = fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  // one operation of n words of random digits; about bad_pct percent of nibbles may exceed nine
  task automatic send_op(action_t act, int n, int bad_pct);
    for (int k = 0; k < n; k++)
      send(act, rand_bcd(bad_pct), rand_bcd(bad_pct), k == n - 1);
  endtask

  task automatic drain();
    while (pending > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    action_t acts[4];
    acts = '{ACT_ADD, ACT_SUB, ACT_MUL, ACT_RSV};
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, every action, short, surplus and bad nibble cases
    send(ACT_ADD, '0, '0, 1);
    send(ACT_ADD, {64{1'b1}}, {64{1'b1}}, 1);
    send(ACT_SUB, 64'h0000000000000001, 64'h0000000000000002, 1);
    send(ACT_MUL, 64'h0000000000000000, 64'h0000000000000000, 0);
    send(ACT_MUL, 64'h0000000000000000, 64'h0000000000000000, 0);
    send(ACT_MUL, 64'h0000000000000000, 64'h0000000000000000, 0);
    send(ACT_MUL, 64'h2000000000000000, 64'h3000000000000000, 1);
    for (int k = 0; k < 8; k++)
      send(ACT_SUB, 64'h9999999999999999, 64'h0123456789012345, 0);
    send(ACT_ADD, 64'hFFFFFFFFFFFFFFFF, 64'hAAAAAAAAAAAAAAAA, 1); // surplus final word
    for (int k = 0; k < 8; k++)
      send(ACT_MUL, (k == 0) ? 64'h9000000000000000 : 64'h5555555555555555,
           64'h1234567890123456, k == 7);
    send(ACT_RSV, 64'h5, 64'h5, 1);
    drain();

    // random phases with different idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 64 : 38) : 0;
      recv_stall = (ph == 2) ? 64 : (ph == 3 ? 38 : 0);
      if (ph == 0) fork
        begin
          hold_off = 1;
          repeat (600) @(negedge clk);
          hold_off = 0;
        end
      join_none
      for (int op = 0; op < 5; op++) begin
        case ($urandom_range(9))
          0: send_op(acts[$urandom_range(3)], $urandom_range(1, 3), 5);
          1: send_op(acts[$urandom_range(3)], $urandom_range(9, 10), 3);
          default: send_op(acts[$urandom_range(3)], 8, ($urandom_range(3) == 0) ? 4 : 0);
        endcase
      end
      drain();
    end

    $display("sent %0d operand items, checked %0d result words over four idling phases",
             items_sent, words_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("decimal_fixed_point_alu_tb OK");
    end else begin
      $display("decimal_fixed_point_alu_tb NOT OK");
    end
    $finish;
  end
endmodule
